/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds on every clock edge outside reset.
`define SCE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// A signal keeps its value into the cycle after one in which a condition holds.
`define SCE_ASSERT_HOLD(label, cond, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |=> $stable(sig)) else $error(msg);

`endif

/* src/sce_pkg.sv */
// ----------------------------------------------------------------------------
// sce_pkg
// Types and constants shared by the seam cumulative energy modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sce_pkg;

    // Field widths.
    localparam int ENERGY_W    = 16;
    localparam int CUM_W       = 32;
    localparam int STEP_W      = 2;
    localparam int CFG_W       = 11;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_PAD_W   = OUT_TDATA_W - CUM_W - STEP_W;

    // Smallest row width that the block runs with.
    localparam int MIN_WIDTH = 8;

    // Row width after reset.
    localparam logic [CFG_W-1:0] WIDTH_RESET = 11'd1024;

    // Predecessor step codes.
    typedef enum logic [STEP_W-1:0] {
        STEP_CENTRE = 2'd0,
        STEP_LEFT   = 2'd1,
        STEP_RIGHT  = 2'd2
    } step_t;

    // Position flags of one pixel within its frame and row.
    typedef struct packed {
        logic first_row;
        logic last;
        logic col_zero;
    } pos_flags_t;

endpackage

`default_nettype wire

/* src/sce_ram.sv */
// ----------------------------------------------------------------------------
// sce_ram
// Generic RAM: one write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sce_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic      [WIDTH-1:0]         rd_data_a,
    output logic      [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read ports, data held while rd_en is low.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem_reg[rd_addr_a];
            rd_data_b <= mem_reg[rd_addr_b];
        end
    end

endmodule

`default_nettype wire

/* src/sce_col_track.sv */
// ----------------------------------------------------------------------------
// sce_col_track
// Column and first-row tracking for the incoming pixel stream.
// ----------------------------------------------------------------------------
`default_nettype none

module sce_col_track #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [sce_pkg::CFG_W-1:0]      width,
    input  wire logic                           advance,
    input  wire logic                           frame_start,
    output logic      [$clog2(MAX_WIDTH)-1:0]   col,
    output sce_pkg::pos_flags_t                 flags
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int CNT_W = $clog2(MAX_WIDTH + 1);
    localparam int EW    = (CNT_W > sce_pkg::CFG_W) ? CNT_W : sce_pkg::CFG_W;

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic             first_reg;
    logic             first_next;
    logic [EW-1:0]    width_ext;
    logic [EW-1:0]    width_eff;
    logic [EW-1:0]    col_plus_one;
    logic             first_cur;
    logic             last_cur;

    // Clamp the configured width to the supported range.
    always_comb
    begin
        width_ext = EW'(width);
        priority if (width_ext < EW'(sce_pkg::MIN_WIDTH))
        begin
            width_eff = EW'(sce_pkg::MIN_WIDTH);
        end
        else if (width_ext > EW'(MAX_WIDTH))
        begin
            width_eff = EW'(MAX_WIDTH);
        end
        else
        begin
            width_eff = width_ext;
        end
    end

    // Position of the pixel now offered; a frame start restarts the count.
    always_comb
    begin
        col          = frame_start ? '0 : col_reg;
        first_cur    = frame_start | first_reg;
        col_plus_one = EW'(col) + EW'(1);
        last_cur     = (col_plus_one >= width_eff);
        col_next     = last_cur ? '0 : col_plus_one[COL_W-1:0];
        first_next   = last_cur ? 1'b0 : first_cur;

        flags.first_row = first_cur;
        flags.last      = last_cur;
        flags.col_zero  = (col == '0);
    end

    // Counter state moves on each accepted pixel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            first_reg <= 1'b1;
        end
        else if (advance)
        begin
            col_reg   <= col_next;
            first_reg <= first_next;
        end
    end

endmodule

`default_nettype wire

/* src/sce_datapath.sv */
// ----------------------------------------------------------------------------
// sce_datapath
// Minimum selection and saturating sum pipeline with stall control.
// ----------------------------------------------------------------------------
`default_nettype none

module sce_datapath #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // Pixel entering the first stage.
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [sce_pkg::ENERGY_W-1:0]     energy,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]     col,
    input  wire sce_pkg::pos_flags_t              flags,
    // Row-above values read for the pixel in the first stage.
    input  wire logic [sce_pkg::CUM_W-1:0]        above,
    input  wire logic [sce_pkg::CUM_W-1:0]        right,
    // Line buffer write-back.
    output logic                                  wr_en,
    output logic      [$clog2(MAX_WIDTH)-1:0]     wr_addr,
    output logic      [sce_pkg::CUM_W-1:0]        wr_data,
    // Result.
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic      [sce_pkg::CUM_W-1:0]        cum,
    output sce_pkg::step_t                        step,
    output logic                                  row_end
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    // Stage 1: input registers, line buffer data alongside.
    logic                            s1_valid_reg;
    logic [sce_pkg::ENERGY_W-1:0]    s1_energy_reg;
    logic [COL_W-1:0]                s1_col_reg;
    sce_pkg::pos_flags_t             s1_flags_reg;
    logic [sce_pkg::CUM_W-1:0]       held_left_reg;

    // Stage 2: centre against left.
    logic                            s2_valid_reg;
    logic [sce_pkg::ENERGY_W-1:0]    s2_energy_reg;
    logic [COL_W-1:0]                s2_col_reg;
    logic                            s2_first_reg;
    logic                            s2_last_reg;
    logic [sce_pkg::CUM_W-1:0]       s2_best_reg;
    sce_pkg::step_t                  s2_step_reg;
    logic [sce_pkg::CUM_W-1:0]       s2_right_reg;

    // Stage 3: against right.
    logic                            s3_valid_reg;
    logic [sce_pkg::ENERGY_W-1:0]    s3_energy_reg;
    logic [COL_W-1:0]                s3_col_reg;
    logic                            s3_first_reg;
    logic                            s3_last_reg;
    logic [sce_pkg::CUM_W-1:0]       s3_best_reg;
    sce_pkg::step_t                  s3_step_reg;

    // Output register.
    logic                            out_valid_reg;
    logic [sce_pkg::CUM_W-1:0]       out_cum_reg;
    sce_pkg::step_t                  out_step_reg;
    logic                            out_last_reg;

    // Stage control.
    logic rdy1, rdy2, rdy3, rdy_out;
    logic acc, adv1, adv2, adv3;

    // Combinational stage results.
    logic                            take_left;
    logic [sce_pkg::CUM_W-1:0]       s2_best_next;
    sce_pkg::step_t                  s2_step_next;
    logic                            take_right;
    logic [sce_pkg::CUM_W-1:0]       s3_best_next;
    sce_pkg::step_t                  s3_step_next;
    logic [sce_pkg::CUM_W:0]         sum_wide;
    logic [sce_pkg::CUM_W-1:0]       sum_next;
    sce_pkg::step_t                  step_next;

    // A stage takes a new item when it is empty or its item moves on.
    always_comb
    begin
        rdy_out  = !out_valid_reg || out_ready;
        rdy3     = !s3_valid_reg || rdy_out;
        rdy2     = !s2_valid_reg || rdy3;
        rdy1     = !s1_valid_reg || rdy2;
        adv3     = s3_valid_reg && rdy_out;
        adv2     = s2_valid_reg && rdy3;
        adv1     = s1_valid_reg && rdy2;
        acc      = in_valid && rdy1;
        in_ready = rdy1;
    end

    // Centre against left; left only replaces on a strictly smaller value.
    always_comb
    begin
        take_left    = !s1_flags_reg.col_zero && (held_left_reg < above);
        s2_best_next = take_left ? held_left_reg : above;
        s2_step_next = take_left ? sce_pkg::STEP_LEFT : sce_pkg::STEP_CENTRE;
    end

    // Right neighbor, absent on the last pixel of a row.
    always_comb
    begin
        take_right   = !s2_last_reg && (s2_right_reg < s2_best_reg);
        s3_best_next = take_right ? s2_right_reg : s2_best_reg;
        s3_step_next = take_right ? sce_pkg::STEP_RIGHT : s2_step_reg;
    end

    // Saturating sum; the first row passes the energy through.
    always_comb
    begin
        sum_wide = {1'b0, s3_best_reg} + (sce_pkg::CUM_W + 1)'(s3_energy_reg);
        if (s3_first_reg)
        begin
            sum_next  = sce_pkg::CUM_W'(s3_energy_reg);
            step_next = sce_pkg::STEP_CENTRE;
        end
        else
        begin
            sum_next  = sum_wide[sce_pkg::CUM_W] ? '1 : sum_wide[sce_pkg::CUM_W-1:0];
            step_next = s3_step_reg;
        end
    end

    // Line buffer write-back as the item leaves stage 3.
    assign wr_en   = adv3;
    assign wr_addr = s3_col_reg;
    assign wr_data = sum_next;

    // Valid bits and the held left value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            held_left_reg <= '0;
        end
        else
        begin
            if (rdy1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (rdy2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (rdy3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (rdy_out)
            begin
                out_valid_reg <= s3_valid_reg;
            end
            if (adv1)
            begin
                held_left_reg <= above;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_energy_reg <= energy;
            s1_col_reg    <= col;
            s1_flags_reg  <= flags;
        end
        if (adv1)
        begin
            s2_energy_reg <= s1_energy_reg;
            s2_col_reg    <= s1_col_reg;
            s2_first_reg  <= s1_flags_reg.first_row;
            s2_last_reg   <= s1_flags_reg.last;
            s2_best_reg   <= s2_best_next;
            s2_step_reg   <= s2_step_next;
            s2_right_reg  <= right;
        end
        if (adv2)
        begin
            s3_energy_reg <= s2_energy_reg;
            s3_col_reg    <= s2_col_reg;
            s3_first_reg  <= s2_first_reg;
            s3_last_reg   <= s2_last_reg;
            s3_best_reg   <= s3_best_next;
            s3_step_reg   <= s3_step_next;
        end
        if (adv3)
        begin
            out_cum_reg  <= sum_next;
            out_step_reg <= step_next;
            out_last_reg <= s3_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign cum       = out_cum_reg;
    assign step      = out_step_reg;
    assign row_end   = out_last_reg;

endmodule

`default_nettype wire

/* src/seam_cumulative_energy_core.sv */
// ----------------------------------------------------------------------------
// seam_cumulative_energy_core
// Vertical seam-carving cumulative energy over a raster pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   Pixel energies enter on the s_t* channel in raster order, one per transfer,
//   with s_tuser marking the first pixel of a new image. Each pixel yields one
//   result on the m_t* channel: the saturating cumulative energy, the step to
//   its predecessor above, and tlast on the last pixel of a row.
//   The row width must be written on the cfg_* channel only while the block is
//   idle; the block itself does not enforce this. Throughput is one pixel per
//   cycle while the receiver keeps m_tready high: the line buffer serves two
//   reads (centre and right above) and one write each cycle. A result passes
//   the input register, the left compare, the right compare and the saturating
//   sum into the output register before it shows on m_tvalid.
//   When the receiver stalls, each stage holds its item and the input keeps
//   accepting until the pipeline is full; no result is lost or repeated.
//   Reset clears all valid bits, sets the row width to 1024 and starts in the
//   first row of a frame; the line buffer is not cleared and needs no pass,
//   since the first row writes every entry that later rows at its width read.
// ----------------------------------------------------------------------------
`default_nettype none

module seam_cumulative_energy_core #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Configuration: image_width.
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [sce_pkg::CFG_W-1:0]           cfg_data,
    // Input stream.
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [sce_pkg::IN_TDATA_W-1:0]      s_tdata,  // [15:0] energy
    input  wire logic [0:0]                          s_tuser,  // [0] frame_start
    // Output stream.
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [31:0] cumulative_energy, [33:32] step_offset, [39:34] zero
    output logic      [sce_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                     m_tlast   // row_end
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic [sce_pkg::CFG_W-1:0]  width_reg;
    logic                       accept;
    logic [COL_W-1:0]           col;
    logic [COL_W-1:0]           col_right;
    sce_pkg::pos_flags_t        flags;
    logic [sce_pkg::CUM_W-1:0]  above;
    logic [sce_pkg::CUM_W-1:0]  right;
    logic                       wr_en;
    logic [COL_W-1:0]           wr_addr;
    logic [sce_pkg::CUM_W-1:0]  wr_data;
    logic [sce_pkg::CUM_W-1:0]  cum;
    sce_pkg::step_t             step;

    // Width register, always ready.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= sce_pkg::WIDTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            width_reg <= cfg_data;
        end
    end

    assign accept    = s_tvalid && s_tready;
    assign col_right = col + COL_W'(1);

    // Column position of the incoming pixel.
    sce_col_track #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_col_track (
        .clk         (clk),
        .rst_n       (rst_n),
        .width       (width_reg),
        .advance     (accept),
        .frame_start (s_tuser[0]),
        .col         (col),
        .flags       (flags)
    );

    // Line buffer holding the cumulative values of the row above.
    sce_ram #(
        .WIDTH (sce_pkg::CUM_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (accept),
        .rd_addr_a (col),
        .rd_addr_b (col_right),
        .rd_data_a (above),
        .rd_data_b (right)
    );

    // Selection and sum pipeline.
    sce_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .energy    (s_tdata[sce_pkg::ENERGY_W-1:0]),
        .col       (col),
        .flags     (flags),
        .above     (above),
        .right     (right),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cum       (cum),
        .step      (step),
        .row_end   (m_tlast)
    );

    assign m_tdata = {{sce_pkg::OUT_PAD_W{1'b0}}, step, cum};

endmodule

`default_nettype wire

/* src/sce_checker.sv */
// ----------------------------------------------------------------------------
// sce_checker
// Port-level checks of the seam cumulative energy core, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sce_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic        m_tlast
);

    // A stalled result keeps its payload until its transfer.
    `SCE_ASSERT_HOLD(a_hold_data, m_tvalid && !m_tready, m_tdata, "stalled m_tdata changed")

    // A stalled result keeps its row end flag until its transfer.
    `SCE_ASSERT_HOLD(a_hold_last, m_tvalid && !m_tready, m_tlast, "stalled m_tlast changed")

    // With the output register empty, the whole pipeline can take a pixel.
    `SCE_ASSERT(a_ready_when_empty, !m_tvalid |-> s_tready, "s_tready low with empty output")

    // The step code is one of centre, left or right.
    `SCE_ASSERT(a_step_code, m_tvalid |-> (m_tdata[33:32] != 2'd3), "invalid step code")

    // Padding bits above the step stay zero.
    `SCE_ASSERT(a_pad_zero, m_tvalid |-> (m_tdata[39:34] == 6'd0), "nonzero tdata padding")

endmodule

bind seam_cumulative_energy_core sce_checker u_sce_checker (.*);

`default_nettype wire

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// Seam cumulative energy testbench
// Streams pixel energies through the core and checks every result against a
// cycle-free predictor of the cumulative energy recurrence, or against the
// expectation a typed row carries. A short directed table covers reset width,
// first-row pass-through, neighbour selection, width clamping, narrowing
// mid-row and frame restarts. A short climb of maximum energies at the
// narrowest width then builds large sums, and random phases follow with varied
// widths, energy mixes, frame starts and handshake idling.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    localparam int CUM_W       = sce_pkg::CUM_W;
    localparam int STEP_W      = sce_pkg::STEP_W;
    localparam int CFG_W       = sce_pkg::CFG_W;
    localparam int IN_TDATA_W  = sce_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W = sce_pkg::OUT_TDATA_W;
    localparam int OUT_PAD_W   = sce_pkg::OUT_PAD_W;
    localparam int MIN_WIDTH   = sce_pkg::MIN_WIDTH;

    localparam int LINE_DEPTH = 1024;
    localparam int CLIMB_ROWS = 8;
    localparam int RANDOM_PHASES = 16;
    localparam int DRAIN_CAP = 20000;
    localparam longint TIMEOUT = 64'd1_000_000;

    // Kinds of rows in the directed table.
    typedef enum logic [1:0] {
        ROW_WIDTH,
        ROW_PIXEL,
        ROW_TYPED
    } row_kind_t;

    // Handshake idling modes.
    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    // Energy mixes for the random phases.
    typedef enum logic [1:0] {
        MIX_FULL,
        MIX_TIES,
        MIX_EXTREME,
        MIX_BLEND
    } energy_mix_t;

    typedef struct packed {
        logic [CUM_W-1:0] cum;
        sce_pkg::step_t   step_dir;
        logic             row_end;
    } pixel_result_t;

    typedef struct packed {
        row_kind_t        kind;
        logic [15:0]      value;
        logic             frame_start;
        logic [CUM_W-1:0] cum;
        sce_pkg::step_t   step_dir;
        logic             row_end;
    } directed_row_t;

    // Directed table: typed rows carry their expected result, plain pixel
    // rows are checked against the predictor, width rows write the register.
    localparam int DIRECTED_ROWS = 25;
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        // First row at the reset width: energy passes straight through.
        '{ROW_TYPED, 16'hFFFF, 1'b1, 32'h0000_FFFF, sce_pkg::STEP_CENTRE, 1'b0},
        '{ROW_TYPED, 16'h0000, 1'b0, 32'h0000_0000, sce_pkg::STEP_CENTRE, 1'b0},
        '{ROW_TYPED, 16'h0003, 1'b0, 32'h0000_0003, sce_pkg::STEP_CENTRE, 1'b0},
        '{ROW_TYPED, 16'h0001, 1'b0, 32'h0000_0001, sce_pkg::STEP_CENTRE, 1'b0},
        '{ROW_TYPED, 16'h0009, 1'b0, 32'h0000_0009, sce_pkg::STEP_CENTRE, 1'b0},
        '{ROW_TYPED, 16'h0002, 1'b0, 32'h0000_0002, sce_pkg::STEP_CENTRE, 1'b0},
        '{ROW_TYPED, 16'h0004, 1'b0, 32'h0000_0004, sce_pkg::STEP_CENTRE, 1'b0},
        '{ROW_TYPED, 16'h0004, 1'b0, 32'h0000_0004, sce_pkg::STEP_CENTRE, 1'b0},
        '{ROW_TYPED, 16'h0007, 1'b0, 32'h0000_0007, sce_pkg::STEP_CENTRE, 1'b0},
        '{ROW_TYPED, 16'h0005, 1'b0, 32'h0000_0005, sce_pkg::STEP_CENTRE, 1'b0},
        // Width below the minimum clamps to eight; column ten now ends the row.
        '{ROW_WIDTH, 16'd7,    1'b0, 32'h0,        sce_pkg::STEP_CENTRE, 1'b0},
        '{ROW_TYPED, 16'h0006, 1'b0, 32'h0000_0006, sce_pkg::STEP_CENTRE, 1'b1},
        // Second row: right, centre, left and tie choices.
        '{ROW_PIXEL, 16'hFFFF, 1'b0, 32'h0,        sce_pkg::STEP_CENTRE, 1'b0},
        '{ROW_PIXEL, 16'h0000, 1'b0, 32'h0,        sce_pkg::STEP_CENTRE, 1'b0},
        '{ROW_PIXEL, 16'h0001, 1'b0, 32'h0,        sce_pkg::STEP_CENTRE, 1'b0},
        '{ROW_PIXEL, 16'h0002, 1'b0, 32'h0,        sce_pkg::STEP_CENTRE, 1'b0},
        '{ROW_PIXEL, 16'h0003, 1'b0, 32'h0,        sce_pkg::STEP_CENTRE, 1'b0},
        '{ROW_PIXEL, 16'h0004, 1'b0, 32'h0,        sce_pkg::STEP_CENTRE, 1'b0},
        '{ROW_PIXEL, 16'h0005, 1'b0, 32'h0,        sce_pkg::STEP_CENTRE, 1'b0},
        '{ROW_PIXEL, 16'h0006, 1'b0, 32'h0,        sce_pkg::STEP_CENTRE, 1'b0},
        // Third row starts, then a frame start cuts it short.
        '{ROW_PIXEL, 16'h0800, 1'b0, 32'h0,        sce_pkg::STEP_CENTRE, 1'b0},
        '{ROW_TYPED, 16'hFFFF, 1'b1, 32'h0000_FFFF, sce_pkg::STEP_CENTRE, 1'b0},
        // Width above the maximum clamps to the line depth.
        '{ROW_WIDTH, 16'd2047, 1'b0, 32'h0,        sce_pkg::STEP_CENTRE, 1'b0},
        '{ROW_TYPED, 16'h1000, 1'b0, 32'h0000_1000, sce_pkg::STEP_CENTRE, 1'b0},
        '{ROW_WIDTH, 16'd0,    1'b0, 32'h0,        sce_pkg::STEP_CENTRE, 1'b0}
    };

    // Block ports.
    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_W-1:0]       cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;   // [15:0] energy
    logic [0:0]             s_tuser = '0;   // [0] frame_start
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;        // [31:0] cum, [33:32] step, [39:34] zero
    logic                   m_tlast;        // row_end

    // Predictor state.
    logic [CUM_W-1:0] above_row [LINE_DEPTH];
    bit               above_written [LINE_DEPTH];
    int unsigned      next_col = 0;
    bit               on_first_row = 1'b1;
    logic [CUM_W-1:0] left_above = '0;
    logic [CFG_W-1:0] width_cfg = sce_pkg::WIDTH_RESET;

    // Results still owed by the block, oldest first.
    pixel_result_t cum_expected [$];

    // Stimulus control and bookkeeping.
    int unsigned sender_gap_pct = 0;
    int unsigned receiver_stall_pct = 0;
    bit          offering = 1'b0;
    int unsigned mismatches = 0;
    int unsigned results_checked = 0;
    int unsigned saturated_seen = 0;
    int unsigned pixels_sent = 0;
    int unsigned frame_starts = 0;
    int unsigned widths_written = 0;

    seam_cumulative_energy_core #(
        .MAX_WIDTH (LINE_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop for a hung handshake.
    initial
    begin
        #(TIMEOUT);
        $display("CHECK FAILED");
        $finish;
    end

    // Row width after clamping into the supported range.
    function automatic int unsigned row_width();
        int unsigned w;
        w = width_cfg;
        if (w < MIN_WIDTH)
            w = MIN_WIDTH;
        if (w > LINE_DEPTH)
            w = LINE_DEPTH;
        return w;
    endfunction

    // True when the next pixel without a frame start would look at a line
    // entry that no earlier row has filled.
    function automatic bit reads_unwritten_line();
        int unsigned col;
        bit          last;
        if (on_first_row)
            return 1'b0;
        col = (next_col >= LINE_DEPTH) ? LINE_DEPTH - 1 : next_col;
        last = (col + 1 >= row_width());
        return !above_written[col] ||
            (!last && col + 1 < LINE_DEPTH && !above_written[col + 1]);
    endfunction

    // Cumulative energy of one pixel; advances the predictor state.
    function automatic pixel_result_t accumulate_pixel(input logic [15:0] e, input bit fs);
        int unsigned      col;
        bit               last;
        logic [CUM_W-1:0] centre;
        logic [CUM_W-1:0] best;
        logic [CUM_W-1:0] sum;
        logic [CUM_W-1:0] e_wide;
        sce_pkg::step_t   dir;
        pixel_result_t    res;
        e_wide = {16'h0000, e};
        if (fs)
        begin
            next_col = 0;
            on_first_row = 1'b1;
        end
        col = (next_col >= LINE_DEPTH) ? LINE_DEPTH - 1 : next_col;
        last = (col + 1 >= row_width());
        centre = above_row[col];
        dir = sce_pkg::STEP_CENTRE;
        if (on_first_row)
            sum = e_wide;
        else
        begin
            // Centre first; left, then right, only when strictly smaller.
            best = centre;
            if (col > 0 && left_above < best)
            begin
                best = left_above;
                dir = sce_pkg::STEP_LEFT;
            end
            if (!last && col + 1 < LINE_DEPTH && above_row[col + 1] < best)
            begin
                best = above_row[col + 1];
                dir = sce_pkg::STEP_RIGHT;
            end
            sum = (best > 32'hFFFF_FFFF - e_wide) ? 32'hFFFF_FFFF : best + e_wide;
        end
        left_above = centre;
        above_row[col] = sum;
        above_written[col] = 1'b1;
        if (last)
        begin
            next_col = 0;
            on_first_row = 1'b0;
        end
        else
            next_col = col + 1;
        res.cum = sum;
        res.step_dir = dir;
        res.row_end = last;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        mismatches++;
        $display("mismatch on result %0d: %s is %0h, expected %0h",
                 results_checked, what, got, want);
    endtask

    task automatic set_idle(input idle_mode_t mode);
        sender_gap_pct = (mode == IDLE_SENDER) ? 59 : (mode == IDLE_BOTH) ? 13 : 0;
        receiver_stall_pct = (mode == IDLE_RECEIVER) ? 59 : (mode == IDLE_BOTH) ? 13 : 0;
    endtask

    // Offer one pixel and wait for its transfer. Typed rows supply their own
    // expectation; all others take the predictor's.
    task automatic feed_pixel(input logic [15:0] e, input bit fs, input bit typed,
                              input pixel_result_t typed_want);
        pixel_result_t predicted;
        if (!fs && reads_unwritten_line())
            fs = 1'b1;
        predicted = accumulate_pixel(e, fs);
        cum_expected = {cum_expected, typed ? typed_want : predicted};
        if (fs)
            frame_starts++;
        // Each idle cycle is drawn on its own, so the sender idles in the
        // given share of cycles.
        if (sender_gap_pct != 0 && $urandom_range(99) < sender_gap_pct)
        begin
            if (offering)
            begin
                s_tvalid <= 1'b0;
                offering = 1'b0;
            end
            do @(posedge clk); while ($urandom_range(99) < sender_gap_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata <= e;
        s_tuser <= fs;
        offering = 1'b1;
        do @(posedge clk); while (!s_tready);
        pixels_sent++;
    endtask

    // Write the row width once every owed result has come back.
    task automatic write_width(input logic [CFG_W-1:0] w);
        if (offering)
        begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
        end
        do @(posedge clk); while (cum_expected.size() != 0);
        cfg_valid <= 1'b1;
        cfg_data <= w;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        width_cfg = w;
        widths_written++;
    endtask

    // Receiver side with random stalls.
    always @(posedge clk)
        m_tready <= (receiver_stall_pct == 0) || ($urandom_range(99) >= receiver_stall_pct);

    // Compare each result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        pixel_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (cum_expected.size() == 0)
                report_mismatch("unexpected result", m_tdata, 0);
            else
            begin
                want = cum_expected.pop_front();
                if (m_tdata[CUM_W-1:0] !== want.cum)
                    report_mismatch("cumulative_energy", m_tdata[CUM_W-1:0], want.cum);
                if (m_tdata[CUM_W +: STEP_W] !== want.step_dir)
                    report_mismatch("step_offset", m_tdata[CUM_W +: STEP_W], want.step_dir);
                if (m_tdata[OUT_TDATA_W-1 -: OUT_PAD_W] !== '0)
                    report_mismatch("tdata padding", m_tdata[OUT_TDATA_W-1 -: OUT_PAD_W], 0);
                if (m_tlast !== want.row_end)
                    report_mismatch("row_end", m_tlast, want.row_end);
            end
            if (m_tdata[CUM_W-1:0] == 32'hFFFF_FFFF)
                saturated_seen++;
            results_checked++;
        end
    end

    // Main sequence.
    initial
    begin
        directed_row_t row;
        pixel_result_t typed_want;
        energy_mix_t   mix;
        int unsigned   phase_items;
        int unsigned   pick;
        int unsigned   sub;
        logic [CFG_W-1:0] w;
        logic [15:0]   e;
        bit            fs;

        for (int i = 0; i < LINE_DEPTH; i++)
        begin
            above_row[i] = '0;
            above_written[i] = 1'b0;
        end

        // Reset.
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        set_idle(IDLE_NONE);
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            row = DIRECTED[i];
            if (row.kind == ROW_WIDTH)
                write_width(row.value[CFG_W-1:0]);
            else
            begin
                typed_want.cum = row.cum;
                typed_want.step_dir = row.step_dir;
                typed_want.row_end = row.row_end;
                feed_pixel(row.value, row.frame_start, row.kind == ROW_TYPED, typed_want);
            end
        end

        // Climb of maximum energies at the narrowest width.
        write_width(11'd8);
        for (int i = 0; i < CLIMB_ROWS * MIN_WIDTH; i++)
            feed_pixel(16'hFFFF, i == 0, 1'b0, typed_want);

        // Random phases: width, energy mix and idling change between phases.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            pick = $urandom_range(99);
            if (phase == 0)
                w = CFG_W'(LINE_DEPTH);
            else if (pick < 55)
                w = CFG_W'($urandom_range(8, 24));
            else if (pick < 65)
                w = CFG_W'($urandom_range(0, 7));
            else if (pick < 75)
                w = CFG_W'(MIN_WIDTH);
            else if (pick < 85)
                w = CFG_W'($urandom_range(25, 64));
            else if (pick < 93)
                w = CFG_W'($urandom_range(1025, 2047));
            else
                w = 11'd2047;
            write_width(w);
            set_idle(idle_mode_t'(phase % 4));
            mix = energy_mix_t'($urandom_range(3));
            // The first phase spans a full-depth row and part of the next.
            phase_items = (phase == 0) ? LINE_DEPTH + $urandom_range(20, 60)
                                       : $urandom_range(25, 50);
            for (int i = 0; i < phase_items; i++)
            begin
                if (i == 0)
                    fs = (phase == 0) || ($urandom_range(99) < 25);
                else
                    fs = ($urandom_range(99) < 2);
                sub = (mix == MIX_BLEND) ? $urandom_range(2) : mix;
                case (energy_mix_t'(sub))
                    MIX_TIES:    e = 16'($urandom_range(3));
                    MIX_EXTREME: e = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                    default:     e = 16'($urandom_range(16'hFFFF));
                endcase
                feed_pixel(e, fs, 1'b0, typed_want);
            end
        end

        // Drain, then allow the pipeline latency to pass.
        if (offering)
        begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
        end
        for (int n = 0; n < DRAIN_CAP && cum_expected.size() != 0; n++)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (cum_expected.size() != 0)
            report_mismatch("results never delivered", cum_expected.size(), 0);

        $display("Streamed %0d pixels with %0d frame starts over %0d width writes.",
                 pixels_sent, frame_starts, widths_written);
        $display("Checked %0d results, %0d of them saturated; %0d mismatches.",
                 results_checked, saturated_seen, mismatches);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
+incdir+src
src/sce_pkg.sv
src/sce_ram.sv
src/sce_col_track.sv
src/sce_datapath.sv
src/seam_cumulative_energy_core.sv
src/sce_checker.sv
dv/testbench.sv
